FILE: hw/rtl/omni_pkg.sv
// Shared constants and types for the three-wheel omni drive kinematics block.
`timescale 1ns / 1ps

package omni_pkg;

  // Default duty width handed to the top level
  localparam int DUTY_BITS_DEF = 10;

  // Fixed widths of the stream fields
  localparam int VEL_W    = 16;  // one velocity field, signed Q4.12
  localparam int VELX_W   = 17;  // velocity after optional negation
  localparam int COEF_W   = 18;  // signed Q.12 coefficient
  localparam int PROD_W   = COEF_W + VELX_W;
  localparam int SPEED_W  = 8;   // whole rad/s, also max_speed width
  localparam int CDUTY_W  = 10;  // width of the duty config registers
  localparam int QUOT_W   = 10;  // quotient bits of the duty scaling divide
  localparam int ACTION_W = 2;
  localparam int NUM_WHEELS = 3;

  // Q.12 coefficients: 1/r, -0.5/r, (sqrt(3)/2)/r and d/r
  localparam logic signed [COEF_W-1:0] K_INV_R    = 18'sd74473;
  localparam logic signed [COEF_W-1:0] K_HALF_NEG = -18'sd37236;
  localparam logic signed [COEF_W-1:0] K_SQRT     = 18'sd64495;
  localparam logic signed [COEF_W-1:0] K_D        = 18'sd11916;

  // Action codes carried on tuser
  localparam logic [ACTION_W-1:0] ACT_VEL    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ENABLE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_ROT = 3'd5;

  // Register reset values
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd60;
  localparam logic [CDUTY_W-1:0] MIN_DUTY_RST  = 10'd0;
  localparam logic [CDUTY_W-1:0] MAX_DUTY_RST  = 10'd1023;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PROD = 8'b0000_0010,
    S_WSPD = 8'b0000_0100,
    S_WMUL = 8'b0000_1000,
    S_DVIN = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_DFIN = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } seq_state_t;

endpackage

FILE: hw/rtl/omni_wheel_kinematics_pwm.sv
// Three-wheel omni drive: velocity command to wheel duty and direction.
//
// Input stream (in_*): one word per command. tuser carries the action (velocity
// command, stop press or enable press); tdata carries vel_x, vel_y, vel_rot.
// Output stream (out_*): exactly one word per input word, with the enable line,
// three direction bits and three duty values as held after that command.
// Config (cfg_*): register writes, always ready; write only while idle.
//
// Flow: stop/enable presses, spare codes, disarmed and all-zero commands go
// from accept straight to the emit state. A driven command issues four
// products on the shared multiplier, then per wheel a speed step and a scale
// multiply, plus the 10-step restoring divide when the wheel is not saturated.
// in_tready is high only while the sequencer is idle, so one command is in
// flight at a time; a new command is taken only once the last one has left
// the sequencer.
// Reset: armed, enable low, all duties and directions zero, registers at
// their defaults. A stalled receiver holds out_tdata; the sequencer finishes
// the next command and waits to hand its word over, then takes no new input.
`timescale 1ns / 1ps

module omni_wheel_kinematics_pwm #(
  parameter int DUTY_BITS = omni_pkg::DUTY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [omni_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [omni_pkg::CDUTY_W-1:0]   cfg_data,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3*omni_pkg::VEL_W-1:0]   in_tdata,  // vel_x, vel_y, vel_rot
  input  logic [omni_pkg::ACTION_W-1:0]  in_tuser,  // action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_enable, dir_one, dir_two, dir_three, duty_one, duty_two, duty_three
  output logic [((4+3*DUTY_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_W = ((4 + 3 * DUTY_BITS + 7) / 8) * 8;
  localparam int VW    = omni_pkg::VEL_W;
  localparam int XW    = omni_pkg::VELX_W;
  localparam int PW    = omni_pkg::PROD_W;
  localparam int CW    = omni_pkg::CDUTY_W;
  localparam int SW    = omni_pkg::SPEED_W;
  localparam int QW    = omni_pkg::QUOT_W;
  localparam logic [CW-1:0] DMASK = CW'((33'd1 << DUTY_BITS) - 33'd1);
  localparam logic [1:0] LAST_WHEEL = 2'(omni_pkg::NUM_WHEELS - 1);
  localparam logic [3:0] LAST_DIV   = 4'(QW - 1);
  localparam logic [2:0] LAST_PROD  = 3'd4;

  // configuration registers
  logic [SW-1:0] max_speed_r;
  logic [CW-1:0] min_duty_r, max_duty_r;
  logic          invert_x_r, invert_y_r, invert_rot_r;

  // block state
  omni_pkg::seq_state_t state_r;
  logic                 armed_r, enable_r;
  logic [DUTY_BITS-1:0] held_duty_r [omni_pkg::NUM_WHEELS];
  logic                 held_dir_r  [omni_pkg::NUM_WHEELS];

  // working registers
  logic signed [XW-1:0] vx_r, vy_r, wrot_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r [omni_pkg::NUM_WHEELS];
  logic [2:0]           step_r;
  logic [1:0]           wheel_r;
  logic [SW-1:0]        spd_r;
  logic                 sat_r;
  logic                 neg_r;
  logic [SW-1:0]        rem_r;
  logic [QW-1:0]        dq_r;
  logic [3:0]           cnt_r;

  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;

  // ---- combinational helpers ----
  logic                 in_fire, out_free;
  logic signed [XW-1:0] vx_in, vy_in, wrot_in;
  logic                 zero_cmd;
  logic [CW-1:0]        min_m, max_m;
  logic signed [CW:0]   diff;
  logic signed [omni_pkg::COEF_W-1:0] mul_a;
  logic signed [XW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] acc_sel, acc_mag;
  logic signed [PW-1:0] prod_mag;
  logic [SW:0]          div_t;
  logic                 div_ge;
  logic signed [CW:0]   q_signed;
  logic signed [CW+1:0] duty_sum;
  logic [OUT_W-1:0]     out_pack;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == omni_pkg::S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // velocities widened by one bit so that negating the most negative code fits
  assign vx_in   = $signed({in_tdata[VW-1],     in_tdata[VW-1:0]});
  assign vy_in   = $signed({in_tdata[2*VW-1],   in_tdata[2*VW-1:VW]});
  assign wrot_in = $signed({in_tdata[3*VW-1],   in_tdata[3*VW-1:2*VW]});
  assign zero_cmd = (in_tdata == '0);

  // duty limits kept to the duty width
  assign min_m = min_duty_r & DMASK;
  assign max_m = max_duty_r & DMASK;
  assign diff  = $signed({1'b0, max_m}) - $signed({1'b0, min_m});

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == omni_pkg::S_WMUL) begin
      mul_a = {{(omni_pkg::COEF_W-CW-1){diff[CW]}}, diff};
      mul_b = $signed({{(XW-SW){1'b0}}, spd_r});
    end else begin
      unique case (step_r)
        3'd0:    begin mul_a = omni_pkg::K_HALF_NEG; mul_b = vx_r;   end
        3'd1:    begin mul_a = omni_pkg::K_D;        mul_b = wrot_r; end
        3'd2:    begin mul_a = omni_pkg::K_SQRT;     mul_b = vy_r;   end
        3'd3:    begin mul_a = omni_pkg::K_INV_R;    mul_b = vx_r;   end
        default: begin mul_a = '0;                   mul_b = '0;     end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // wheel speed magnitude, whole rad/s in bits 31:24 of the Q.24 value
  assign acc_sel = acc_r[wheel_r];
  assign acc_mag = acc_sel[PW-1] ? -acc_sel : acc_sel;

  // divide set-up and one restoring step
  assign prod_mag = prod_r[PW-1] ? -prod_r : prod_r;
  assign div_t    = {rem_r, dq_r[QW-1]};
  assign div_ge   = (div_t >= {1'b0, max_speed_r});

  // signed quotient plus offset
  assign q_signed = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
  assign duty_sum = $signed({q_signed[CW], q_signed}) + $signed({2'b00, min_m});

  // result word
  always_comb begin
    out_pack = '0;
    out_pack[0] = enable_r;
    out_pack[1] = held_dir_r[0];
    out_pack[2] = held_dir_r[1];
    out_pack[3] = held_dir_r[2];
    out_pack[4 +: DUTY_BITS]               = held_duty_r[0];
    out_pack[4 + DUTY_BITS +: DUTY_BITS]   = held_duty_r[1];
    out_pack[4 + 2*DUTY_BITS +: DUTY_BITS] = held_duty_r[2];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= omni_pkg::MAX_SPEED_RST;
      min_duty_r   <= omni_pkg::MIN_DUTY_RST;
      max_duty_r   <= omni_pkg::MAX_DUTY_RST;
      invert_x_r   <= 1'b0;
      invert_y_r   <= 1'b0;
      invert_rot_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        omni_pkg::REG_MAX_SPEED:  max_speed_r  <= cfg_data[SW-1:0];
        omni_pkg::REG_MIN_DUTY:   min_duty_r   <= cfg_data;
        omni_pkg::REG_MAX_DUTY:   max_duty_r   <= cfg_data;
        omni_pkg::REG_INVERT_X:   invert_x_r   <= cfg_data[0];
        omni_pkg::REG_INVERT_Y:   invert_y_r   <= cfg_data[0];
        omni_pkg::REG_INVERT_ROT: invert_rot_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // multiplier output register, loaded every cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= omni_pkg::S_IDLE;
      armed_r      <= 1'b1;
      enable_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      step_r       <= '0;
      wheel_r      <= '0;
      cnt_r        <= '0;
      for (int k = 0; k < omni_pkg::NUM_WHEELS; k++) begin
        held_duty_r[k] <= '0;
        held_dir_r[k]  <= 1'b0;
      end
    end else begin
      // result valid: set when a word is loaded, cleared once taken
      if (state_r == omni_pkg::S_EMIT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        // decode the action; only a driven command goes through the datapath
        omni_pkg::S_IDLE: begin
          if (in_fire) begin
            state_r <= omni_pkg::S_EMIT;
            priority if (in_tuser == omni_pkg::ACT_STOP) begin
              armed_r  <= 1'b0;
              enable_r <= 1'b0;
            end else if (in_tuser == omni_pkg::ACT_ENABLE) begin
              armed_r <= 1'b1;
            end else if (in_tuser == omni_pkg::ACT_VEL) begin
              if (!armed_r || zero_cmd) begin
                enable_r <= 1'b0;
              end else begin
                enable_r <= 1'b1;
                vx_r     <= invert_x_r   ? -vx_in   : vx_in;
                vy_r     <= invert_y_r   ? -vy_in   : vy_in;
                wrot_r   <= invert_rot_r ? -wrot_in : wrot_in;
                step_r   <= '0;
                wheel_r  <= '0;
                state_r  <= omni_pkg::S_PROD;
              end
            end else begin
              // unused action code: nothing changes
            end
          end
        end

        // four products, each accumulated the cycle after it is issued
        omni_pkg::S_PROD: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd1: begin
              acc_r[0] <= prod_r;
              acc_r[1] <= prod_r;
            end
            3'd2: begin
              acc_r[0] <= acc_r[0] + prod_r;
              acc_r[1] <= acc_r[1] + prod_r;
              acc_r[2] <= prod_r;
            end
            3'd3: begin
              acc_r[0] <= acc_r[0] + prod_r;
              acc_r[1] <= acc_r[1] - prod_r;
            end
            3'd4: begin
              acc_r[2] <= acc_r[2] + prod_r;
            end
            default: ;
          endcase
          if (step_r == LAST_PROD) begin
            state_r <= omni_pkg::S_WSPD;
          end
        end

        // direction, whole speed and saturation for the current wheel
        omni_pkg::S_WSPD: begin
          held_dir_r[wheel_r] <= !acc_sel[PW-1];
          spd_r   <= acc_mag[31:24];
          sat_r   <= (acc_mag[31:24] >= max_speed_r);
          state_r <= omni_pkg::S_WMUL;
        end

        // saturated wheels take max duty; others scale speed by the duty span
        omni_pkg::S_WMUL: begin
          if (sat_r) begin
            held_duty_r[wheel_r] <= DUTY_BITS'(max_m);
            if (wheel_r == LAST_WHEEL) begin
              state_r <= omni_pkg::S_EMIT;
            end else begin
              wheel_r <= wheel_r + 2'd1;
              state_r <= omni_pkg::S_WSPD;
            end
          end else begin
            state_r <= omni_pkg::S_DVIN;
          end
        end

        // load divider; the quotient fits in QUOT_W bits
        omni_pkg::S_DVIN: begin
          neg_r   <= prod_r[PW-1];
          rem_r   <= prod_mag[QW+SW-1:QW];
          dq_r    <= prod_mag[QW-1:0];
          cnt_r   <= '0;
          state_r <= omni_pkg::S_DIV;
        end

        // one quotient bit per cycle
        omni_pkg::S_DIV: begin
          rem_r <= div_ge ? SW'(div_t - {1'b0, max_speed_r}) : div_t[SW-1:0];
          dq_r  <= {dq_r[QW-2:0], div_ge};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == LAST_DIV) begin
            state_r <= omni_pkg::S_DFIN;
          end
        end

        // apply sign and offset, move on to the next wheel
        omni_pkg::S_DFIN: begin
          held_duty_r[wheel_r] <= DUTY_BITS'(duty_sum[CW-1:0]);
          if (wheel_r == LAST_WHEEL) begin
            state_r <= omni_pkg::S_EMIT;
          end else begin
            wheel_r <= wheel_r + 2'd1;
            state_r <= omni_pkg::S_WSPD;
          end
        end

        // hand the word over once the output register is free
        omni_pkg::S_EMIT: begin
          if (out_free) begin
            out_tdata_r  <= out_pack;
            state_r      <= omni_pkg::S_IDLE;
          end
        end

        default: state_r <= omni_pkg::S_IDLE;
      endcase
    end
  end

endmodule

FILE: test/drive_checker.sv
// Checker for the omni drive block: predicts every result word and compares it.
`timescale 1ns / 1ps

module drive_checker #(
  parameter int DUTY_BITS = omni_pkg::DUTY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [omni_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [omni_pkg::CDUTY_W-1:0]   cfg_data,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [3*omni_pkg::VEL_W-1:0]   in_tdata,   // vel_x, vel_y, vel_rot
  input  logic [omni_pkg::ACTION_W-1:0]  in_tuser,   // action
  input  logic out_tvalid,
  input  logic out_tready,
  // drive_enable, dir_one, dir_two, dir_three, duty_one, duty_two, duty_three
  input  logic [((4+3*DUTY_BITS+7)/8)*8-1:0] out_tdata,
  output int   fail_count,
  output int   outstanding
);

  localparam int VW = omni_pkg::VEL_W;

  // Q.12 wheel coefficients: 1/r, 0.5/r, (sqrt(3)/2)/r, d/r with r = 0.055, d = 0.16
  localparam longint GAIN_INV_R = 74473;
  localparam longint GAIN_HALF  = 37236;
  localparam longint GAIN_SQRT  = 64495;
  localparam longint GAIN_DIST  = 11916;

  // result word, drive_enable in bit 0
  typedef struct packed {
    logic [DUTY_BITS-1:0] duty_three;
    logic [DUTY_BITS-1:0] duty_two;
    logic [DUTY_BITS-1:0] duty_one;
    logic                 dir_three;
    logic                 dir_two;
    logic                 dir_one;
    logic                 drive_enable;
  } drive_word_t;

  // register copies
  logic [7:0]           speed_cap;
  logic [DUTY_BITS-1:0] duty_floor;
  logic [DUTY_BITS-1:0] duty_ceil;
  logic                 flip_x, flip_y, flip_rot;

  // drive state
  logic                 armed;
  logic                 enable_level;
  logic [DUTY_BITS-1:0] held_duty [3];
  logic                 held_dir  [3];

  drive_word_t expected_words[$];
  int accepted, returned;
  int mismatches = 0;

  assign fail_count  = mismatches;
  assign outstanding = accepted - returned;

  // direction and duty of one wheel from its Q.24 speed
  function automatic void steer_wheel(int k, longint spd);
    longint mag, whole, lo, hi, cap, duty;
    lo    = longint'(duty_floor);
    hi    = longint'(duty_ceil);
    cap   = longint'(speed_cap);
    held_dir[k] = (spd >= 0);
    mag   = (spd >= 0) ? spd : -spd;
    whole = mag >>> 24;
    if (whole >= cap) begin
      duty = hi;
    end else begin
      duty = (whole * (hi - lo)) / cap + lo;
    end
    held_duty[k] = duty[DUTY_BITS-1:0];
  endfunction

  // advance the drive state by one command and queue the word it produces
  function automatic void take_command(logic [omni_pkg::ACTION_W-1:0] act,
                                       longint vx, longint vy, longint vr);
    longint      shared;
    drive_word_t w;
    case (act)
      omni_pkg::ACT_STOP: begin
        armed        = 1'b0;
        enable_level = 1'b0;
      end
      omni_pkg::ACT_ENABLE: begin
        armed = 1'b1;
      end
      omni_pkg::ACT_VEL: begin
        if (!armed || (vx == 0 && vy == 0 && vr == 0)) begin
          enable_level = 1'b0;
        end else begin
          enable_level = 1'b1;
          if (flip_x)   vx = -vx;
          if (flip_y)   vy = -vy;
          if (flip_rot) vr = -vr;
          shared = -GAIN_HALF * vx + GAIN_DIST * vr;
          steer_wheel(0, shared + GAIN_SQRT * vy);
          steer_wheel(1, shared - GAIN_SQRT * vy);
          steer_wheel(2, GAIN_INV_R * vx + GAIN_DIST * vr);
        end
      end
      default: ;  // spare code leaves everything alone
    endcase
    w.drive_enable = enable_level;
    w.dir_one      = held_dir[0];
    w.dir_two      = held_dir[1];
    w.dir_three    = held_dir[2];
    w.duty_one     = held_duty[0];
    w.duty_two     = held_duty[1];
    w.duty_three   = held_duty[2];
    expected_words.push_back(w);
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // watch all three channels on the rising edge
  always @(posedge clk) begin
    drive_word_t want, got;
    if (!rst_n) begin
      speed_cap    = 8'd60;
      duty_floor   = '0;
      duty_ceil    = '1;
      flip_x       = 1'b0;
      flip_y       = 1'b0;
      flip_rot     = 1'b0;
      armed        = 1'b1;
      enable_level = 1'b0;
      for (int k = 0; k < 3; k++) begin
        held_duty[k] = '0;
        held_dir[k]  = 1'b0;
      end
      expected_words.delete();
      accepted <= 0;
      returned <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          omni_pkg::REG_MAX_SPEED:  speed_cap  = cfg_data[7:0];
          omni_pkg::REG_MIN_DUTY:   duty_floor = DUTY_BITS'(cfg_data);
          omni_pkg::REG_MAX_DUTY:   duty_ceil  = DUTY_BITS'(cfg_data);
          omni_pkg::REG_INVERT_X:   flip_x     = cfg_data[0];
          omni_pkg::REG_INVERT_Y:   flip_y     = cfg_data[0];
          omni_pkg::REG_INVERT_ROT: flip_rot   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        take_command(in_tuser,
                     longint'($signed(in_tdata[VW-1:0])),
                     longint'($signed(in_tdata[2*VW-1:VW])),
                     longint'($signed(in_tdata[3*VW-1:2*VW])));
        accepted <= accepted + 1;
      end
      if (out_tvalid && out_tready) begin
        returned <= returned + 1;
        got = out_tdata[$bits(drive_word_t)-1:0];
        if (expected_words.size() == 0) begin
          $error("result word with no command pending: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("drive_enable", want.drive_enable, got.drive_enable);
          check_field("dir_one",      want.dir_one,      got.dir_one);
          check_field("dir_two",      want.dir_two,      got.dir_two);
          check_field("dir_three",    want.dir_three,    got.dir_three);
          check_field("duty_one",     want.duty_one,     got.duty_one);
          check_field("duty_two",     want.duty_two,     got.duty_two);
          check_field("duty_three",   want.duty_three,   got.duty_three);
        end
      end
    end
  end

endmodule

FILE: test/testbench.sv
// Top of the omni drive bench: clock, reset, command and register stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int DUTY_BITS = omni_pkg::DUTY_BITS_DEF;
  localparam int OUT_W     = ((4+3*DUTY_BITS+7)/8)*8;
  localparam int VW        = omni_pkg::VEL_W;
  localparam logic [omni_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;  // unused code
  localparam int PHASE_WORDS = 75;
  localparam int SETTLE      = 60;   // beyond the longest command latency

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [omni_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [omni_pkg::CDUTY_W-1:0]   cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [3*VW-1:0] in_tdata = '0;                 // vel_x, vel_y, vel_rot
  logic [omni_pkg::ACTION_W-1:0] in_tuser = '0;   // action
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;  // drive_enable, dir_one..three, duty_one..three

  int  fail_count, outstanding;
  bit  calm = 1'b0;   // when set both sides run without gaps

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  omni_wheel_kinematics_pwm #(.DUTY_BITS(DUTY_BITS)) dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  drive_checker #(.DUTY_BITS(DUTY_BITS)) scoreboard (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .outstanding
  );

  // hand one command word over, after a random gap unless calm is set
  task automatic send_command(input logic [omni_pkg::ACTION_W-1:0] act,
                              input logic [VW-1:0] vx, input logic [VW-1:0] vy,
                              input logic [VW-1:0] vr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {vr, vy, vx};
    do @(posedge clk); while (!in_tready);
  endtask

  // let every result drain, then some quiet cycles
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [omni_pkg::CFG_IDX_W-1:0] idx,
                         input logic [omni_pkg::CDUTY_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, written while the block is idle
  task automatic load_settings(input logic [7:0] speed, input logic [9:0] lo,
                               input logic [9:0] hi, input logic ix,
                               input logic iy, input logic ir);
    put_reg(omni_pkg::REG_MAX_SPEED,  {2'b00, speed});
    put_reg(omni_pkg::REG_MIN_DUTY,   lo);
    put_reg(omni_pkg::REG_MAX_DUTY,   hi);
    put_reg(omni_pkg::REG_INVERT_X,   {9'd0, ix});
    put_reg(omni_pkg::REG_INVERT_Y,   {9'd0, iy});
    put_reg(omni_pkg::REG_INVERT_ROT, {9'd0, ir});
    cfg_valid <= 1'b0;
  endtask

  // mixed magnitudes: zero, full range, within the duty map, below 1 rad/s, extremes
  function automatic logic [VW-1:0] pick_velocity();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return VW'($urandom());
      3, 4:    return VW'(int'($urandom_range(0, 16383)) - 8192);
      5:       return VW'(int'($urandom_range(0, 1023)) - 512);
      6:       return 16'h7fff;
      default: return 16'h8000;
    endcase
  endfunction

  // mostly driven commands, with button presses, zero and spare words mixed in
  task automatic random_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)
      send_command(omni_pkg::ACT_STOP, VW'($urandom()), VW'($urandom()), VW'($urandom()));
    else if (roll < 11)
      send_command(omni_pkg::ACT_ENABLE, VW'($urandom()), VW'($urandom()),
                   VW'($urandom()));
    else if (roll < 13)
      send_command(ACT_SPARE, VW'($urandom()), VW'($urandom()), VW'($urandom()));
    else if (roll < 17)
      send_command(omni_pkg::ACT_VEL, '0, '0, '0);
    else
      send_command(omni_pkg::ACT_VEL, pick_velocity(), pick_velocity(), pick_velocity());
  endtask

  task automatic random_phase();
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if (n % 25 == 0) calm = ($urandom_range(0, 3) == 0);
      random_command();
    end
    calm = 1'b0;
  endtask

  // result side: random stall before every word unless calm is set
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // stimulus and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: extremes, single axes, button sequences
    send_command(omni_pkg::ACT_VEL, '0, '0, '0);
    send_command(omni_pkg::ACT_VEL, 16'h7fff, 16'h7fff, 16'h7fff);
    send_command(omni_pkg::ACT_VEL, 16'h8000, 16'h8000, 16'h8000);
    send_command(omni_pkg::ACT_VEL, 16'h7fff, '0, '0);
    send_command(omni_pkg::ACT_VEL, '0, 16'h8000, '0);
    send_command(omni_pkg::ACT_VEL, '0, '0, 16'h7fff);
    send_command(omni_pkg::ACT_VEL, 16'd4096, '0, '0);
    send_command(omni_pkg::ACT_VEL, 16'd1, 16'hffff, 16'd1);
    send_command(omni_pkg::ACT_VEL, 16'h8000, 16'h7fff, 16'h8000);
    send_command(ACT_SPARE, 16'h1234, 16'h8765, 16'hffff);
    send_command(omni_pkg::ACT_STOP, '0, '0, '0);
    send_command(omni_pkg::ACT_VEL, 16'd8000, -16'sd3000, 16'd500);
    send_command(omni_pkg::ACT_ENABLE, '0, '0, '0);
    send_command(omni_pkg::ACT_VEL, 16'd8000, -16'sd3000, 16'd500);
    send_command(omni_pkg::ACT_ENABLE, 16'hffff, 16'hffff, 16'hffff);
    send_command(omni_pkg::ACT_VEL, '0, '0, '0);
    send_command(omni_pkg::ACT_STOP, '0, '0, '0);
    send_command(omni_pkg::ACT_STOP, '0, '0, '0);
    send_command(omni_pkg::ACT_ENABLE, '0, '0, '0);
    send_command(omni_pkg::ACT_VEL, -16'sd4096, 16'd4096, -16'sd4096);
    send_command(ACT_SPARE, '0, '0, '0);
    settle();

    // downward map with a small speed cap, all axes flipped
    load_settings(8'd10, 10'd100, 10'd50, 1'b1, 1'b1, 1'b1);
    send_command(omni_pkg::ACT_VEL, 16'd2000, -16'sd1000, 16'd300);
    send_command(omni_pkg::ACT_VEL, 16'd200, 16'd100, -16'sd50);
    send_command(omni_pkg::ACT_VEL, 16'h8000, 16'h7fff, 16'h8000);
    settle();

    // fixed corners, then random settings
    load_settings(8'd255, 10'd0, 10'd1023, 1'b0, 1'b0, 1'b0);
    random_phase();
    settle();
    load_settings(8'd1, 10'd1023, 10'd0, 1'b1, 1'b1, 1'b1);
    random_phase();
    settle();
    load_settings(8'd0, 10'd5, 10'd700, 1'b1, 1'b0, 1'b0);
    random_phase();
    settle();
    load_settings(8'd200, 10'd300, 10'd300, 1'b0, 1'b1, 1'b0);
    random_phase();
    settle();
    for (int p = 0; p < 4; p++) begin
      load_settings(8'($urandom_range(1, 255)), 10'($urandom()), 10'($urandom()),
                    1'($urandom()), 1'($urandom()), 1'($urandom()));
      random_phase();
      settle();
    end

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: omni_wheel_kinematics_pwm.f
hw/rtl/omni_pkg.sv
hw/rtl/omni_wheel_kinematics_pwm.sv
test/drive_checker.sv
test/testbench.sv
